FILE: hw/rtl/afsp_pkg.sv
// Shared constants, types and helpers of the ASCII frame speed parser.
package afsp_pkg;

  localparam int FRAME_LENGTH = 15;
  localparam int POS_W        = 4;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;

  typedef logic [POS_W-1:0] pos_t;

  // Byte positions within a frame
  localparam pos_t POS_START    = POS_W'(0);
  localparam pos_t POS_ADDR_HI  = POS_W'(1);
  localparam pos_t POS_ADDR_LO  = POS_W'(2);
  localparam pos_t POS_FUNC_HI  = POS_W'(3);
  localparam pos_t POS_FUNC_LO  = POS_W'(4);
  localparam pos_t POS_REG_HI   = POS_W'(5);
  localparam pos_t POS_REG_LO   = POS_W'(6);
  localparam pos_t POS_SIGN     = POS_W'(7);
  localparam pos_t POS_DATA_HI  = POS_W'(8);
  localparam pos_t POS_DATA_MID = POS_W'(9);
  localparam pos_t POS_DATA_LO  = POS_W'(10);
  localparam pos_t POS_LRC_HI   = POS_W'(11);
  localparam pos_t POS_LRC_LO   = POS_W'(12);
  localparam pos_t POS_CR       = POS_W'(13);
  localparam pos_t POS_LF       = POS_W'(FRAME_LENGTH - 1);

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [7:0]  FUNC_WRITE_REG = 8'h06;
  localparam logic [7:0]  REG_SPEED      = 8'h20;
  localparam logic [10:0] DATA_CLAMP     = 11'h500;
  localparam logic [11:0] SPEED_MUL      = 12'd3331;
  localparam int          SPEED_SHIFT    = 13;
  localparam int          PROD_W         = 23;

  localparam logic [15:0] OWN_ADDR_RESET = 16'h4432;
  localparam logic        REG_OWN_ADDR   = 1'b0;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_DELIM = 3'd1,
    ST_ADDR  = 3'd2,
    ST_LRC   = 3'd3,
    ST_CODE  = 3'd4
  } status_t;

  typedef struct packed {
    logic signed [10:0] speed_hundredths;
    logic [2:0]         frame_status;
  } result_t;

  // Hex character to digit; letters A to O land at 10..24
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    begin
      d = {1'b0, c[3:0]};
      if (c > CHAR_NINE) begin
        d = d + 5'd9;
      end
      return d;
    end
  endfunction

endpackage

FILE: hw/rtl/afsp_if.sv
// Valid/ready channel interfaces for received bytes and parse results.
interface afsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_restart;

  modport source (output valid, output rx_byte, output frame_restart, input ready);
  modport sink   (input valid, input rx_byte, input frame_restart, output ready);
endinterface

interface afsp_out_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] speed_hundredths;
  logic [2:0]         frame_status;

  modport source (output valid, output speed_hundredths, output frame_status, input ready);
  modport sink   (input valid, input speed_hundredths, input frame_status, output ready);
endinterface

FILE: hw/rtl/ascii_frame_speed_parser_core.sv
// Top level of the ASCII frame speed parser: byte input, result output, APB registers.
//
//  channel | dir | payload                               | handshake
//  --------+-----+---------------------------------------+-----------------
//  in_ch   | in  | rx_byte[7:0], frame_restart           | valid / ready
//  out_ch  | out | speed_hundredths[10:0] s, frame_status| valid / ready
//  APB     | in  | own_address_chars at byte address 0   | psel/penable, pready=1
//
// One word per cycle sustained: a byte is held in the input register, then
// the frame decode updates its state as the byte leaves that register.
// The line-feed byte's result is captured in the output register at the same edge
// that byte leaves the input register, so out_ch.valid rises once the last byte
// has passed through the input register.
// Non-final bytes keep flowing while a result waits on out_ch; only a final byte
// stalls behind an untaken result. Synchronous active-low reset clears position,
// sums and fields to zero and the address register to 'D','2'.
module ascii_frame_speed_parser_core (
  input  logic                        clk,
  input  logic                        rst_n,
  afsp_in_if.sink                     in_ch,
  afsp_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [afsp_pkg::ADDR_W-1:0] paddr,
  input  logic [afsp_pkg::DATA_W-1:0] pwdata,
  output logic [afsp_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  // Input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_restart_r;

  // Output register
  logic              out_valid_r;
  afsp_pkg::result_t out_result_r;

  logic              s1_adv;
  logic              in_fire;
  logic              is_last;
  logic [15:0]       own_addr;
  afsp_pkg::result_t frame_result;

  afsp_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .own_addr (own_addr)
  );

  afsp_frame u_frame (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (s1_adv),
    .rx_byte       (s1_byte_r),
    .frame_restart (s1_restart_r),
    .own_addr      (own_addr),
    .is_last       (is_last),
    .result        (frame_result)
  );

  // Advance the held word unless it is a final byte and the result slot is still full
  assign s1_adv      = s1_valid_r && (!is_last || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  // Capture payload on accept; no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r    <= in_ch.rx_byte;
      s1_restart_r <= in_ch.frame_restart;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && is_last) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && is_last) begin
      out_result_r <= frame_result;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.speed_hundredths = out_result_r.speed_hundredths;
  assign out_ch.frame_status     = out_result_r.frame_status;

  // A failed frame never carries a speed
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_result_r.frame_status != afsp_pkg::ST_OK))
      |-> (out_result_r.speed_hundredths == 11'sd0))
    else $error("nonzero speed on failed frame");

  // Status stays within the defined codes
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_result_r.frame_status <= afsp_pkg::ST_CODE))
    else $error("undefined frame status");

  // A new result only follows a final byte leaving the input register
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && is_last))
    else $error("result without final byte");

  // Speed magnitude bounded by the clamp
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_result_r.speed_hundredths <= 11'sd520) &&
                     (out_result_r.speed_hundredths >= -11'sd520)))
    else $error("speed out of range");

endmodule

FILE: hw/rtl/afsp_cfg.sv
// APB register file holding the own-address characters.
module afsp_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [afsp_pkg::ADDR_W-1:0]  paddr,
  input  logic [afsp_pkg::DATA_W-1:0]  pwdata,
  output logic [afsp_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [15:0]                  own_addr
);

  logic [15:0] own_addr_r;
  logic        sel_own;

  assign sel_own  = (paddr[2] == afsp_pkg::REG_OWN_ADDR);
  assign pready   = 1'b1;
  assign own_addr = own_addr_r;
  assign prdata   = sel_own ? {16'h0000, own_addr_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= afsp_pkg::OWN_ADDR_RESET;
    end else if (psel && penable && pwrite && sel_own) begin
      own_addr_r <= pwdata[15:0];
    end
  end

endmodule

FILE: hw/rtl/afsp_frame.sv
// Frame position, field decode, LRC accumulation and final verdict.
module afsp_frame (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  logic                frame_restart,
  input  logic [15:0]         own_addr,
  output logic                is_last,
  output afsp_pkg::result_t   result
);

  afsp_pkg::pos_t pos_r, pos_nxt, pos;
  logic [7:0]  lrc_r, lrc_nxt;
  logic        start_ok_r, start_ok_nxt;
  logic        addr_match_r, addr_match_nxt;
  logic [7:0]  func_r, func_nxt;
  logic [7:0]  reg_r, reg_nxt;
  logic        neg_r, neg_nxt;
  logic [11:0] data_r, data_nxt;
  logic [7:0]  rlrc_r, rlrc_nxt;
  logic        cr_ok_r, cr_ok_nxt;

  logic [4:0]                     d;
  logic [10:0]                    clamped;
  logic [afsp_pkg::PROD_W-1:0]    prod;
  logic [9:0]                     mag;
  afsp_pkg::status_t              status;

  assign d   = afsp_pkg::hex_digit(rx_byte);
  assign pos = (frame_restart || (pos_r >= afsp_pkg::POS_W'(afsp_pkg::FRAME_LENGTH)))
               ? afsp_pkg::POS_START : pos_r;
  assign is_last = (pos == afsp_pkg::POS_LF);

  always_comb begin
    lrc_nxt        = lrc_r;
    start_ok_nxt   = start_ok_r;
    addr_match_nxt = addr_match_r;
    func_nxt       = func_r;
    reg_nxt        = reg_r;
    neg_nxt        = neg_r;
    data_nxt       = data_r;
    rlrc_nxt       = rlrc_r;
    cr_ok_nxt      = cr_ok_r;
    pos_nxt        = is_last ? afsp_pkg::POS_START : pos + afsp_pkg::POS_W'(1);

    if (pos == afsp_pkg::POS_START) begin
      lrc_nxt = rx_byte;
    end else if (pos <= afsp_pkg::POS_DATA_LO) begin
      lrc_nxt = lrc_r + rx_byte;
    end

    case (pos)
      afsp_pkg::POS_START:    start_ok_nxt   = (rx_byte == afsp_pkg::CHAR_COLON);
      afsp_pkg::POS_ADDR_HI:  addr_match_nxt = (rx_byte == own_addr[15:8]);
      afsp_pkg::POS_ADDR_LO:  addr_match_nxt = addr_match_r && (rx_byte == own_addr[7:0]);
      afsp_pkg::POS_FUNC_HI:  func_nxt = d[4] ? 8'hFF : {d[3:0], 4'h0};
      afsp_pkg::POS_FUNC_LO:  func_nxt = func_r | {3'b000, d};
      afsp_pkg::POS_REG_HI:   reg_nxt  = d[4] ? 8'hFF : {d[3:0], 4'h0};
      afsp_pkg::POS_REG_LO:   reg_nxt  = reg_r | {3'b000, d};
      afsp_pkg::POS_SIGN:     neg_nxt  = (rx_byte == afsp_pkg::CHAR_MINUS);
      afsp_pkg::POS_DATA_HI:  data_nxt = d[4] ? 12'hFFF : {d[3:0], 8'h00};
      afsp_pkg::POS_DATA_MID: data_nxt = data_r | {3'b000, d, 4'h0};
      afsp_pkg::POS_DATA_LO:  data_nxt = data_r | {7'b0000000, d};
      afsp_pkg::POS_LRC_HI:   rlrc_nxt = {d[3:0], 4'h0};
      afsp_pkg::POS_LRC_LO:   rlrc_nxt = rlrc_r | {3'b000, d};
      afsp_pkg::POS_CR:       cr_ok_nxt = (rx_byte == afsp_pkg::CHAR_CR);
      default: ;
    endcase
  end

  // Verdict on the line-feed byte; nothing but the LF byte itself changes then
  always_comb begin
    if (!(start_ok_r && cr_ok_r && (rx_byte == afsp_pkg::CHAR_LF))) begin
      status = afsp_pkg::ST_DELIM;
    end else if (!addr_match_r) begin
      status = afsp_pkg::ST_ADDR;
    end else if ((8'd0 - lrc_r) != rlrc_r) begin
      status = afsp_pkg::ST_LRC;
    end else if ((func_r != afsp_pkg::FUNC_WRITE_REG) || (reg_r != afsp_pkg::REG_SPEED)) begin
      status = afsp_pkg::ST_CODE;
    end else begin
      status = afsp_pkg::ST_OK;
    end
  end

  assign clamped = (data_r > {1'b0, afsp_pkg::DATA_CLAMP}) ? afsp_pkg::DATA_CLAMP
                   : data_r[10:0];
  assign prod    = afsp_pkg::PROD_W'(clamped) * afsp_pkg::PROD_W'(afsp_pkg::SPEED_MUL);
  assign mag     = prod[afsp_pkg::PROD_W-1:afsp_pkg::SPEED_SHIFT];

  always_comb begin
    result.frame_status = status;
    if (status != afsp_pkg::ST_OK) begin
      result.speed_hundredths = '0;
    end else if (neg_r) begin
      result.speed_hundredths = 11'sd0 - $signed({1'b0, mag});
    end else begin
      result.speed_hundredths = $signed({1'b0, mag});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= afsp_pkg::POS_START;
      lrc_r        <= '0;
      start_ok_r   <= 1'b0;
      addr_match_r <= 1'b0;
      func_r       <= '0;
      reg_r        <= '0;
      neg_r        <= 1'b0;
      data_r       <= '0;
      rlrc_r       <= '0;
      cr_ok_r      <= 1'b0;
    end else if (step) begin
      pos_r        <= pos_nxt;
      lrc_r        <= lrc_nxt;
      start_ok_r   <= start_ok_nxt;
      addr_match_r <= addr_match_nxt;
      func_r       <= func_nxt;
      reg_r        <= reg_nxt;
      neg_r        <= neg_nxt;
      data_r       <= data_nxt;
      rlrc_r       <= rlrc_nxt;
      cr_ok_r      <= cr_ok_nxt;
    end
  end

endmodule

FILE: tb/sv/afsp_frame_checker.sv
`timescale 1ns / 100ps
// Frame checker: watches the byte, result and register ports, predicts and compares results.
module afsp_frame_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rx_valid,
  input  logic                          rx_ready,
  input  logic [7:0]                    rx_byte,
  input  logic                          rx_restart,
  input  logic                          res_valid,
  input  logic                          res_ready,
  input  logic signed [10:0]            res_speed,
  input  logic [2:0]                    res_status,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [afsp_pkg::ADDR_W-1:0]   paddr,
  input  logic [afsp_pkg::DATA_W-1:0]   pwdata,
  output int                            mismatch_count,
  output int                            results_pending
);

  afsp_pkg::pos_t    byte_pos;
  logic [7:0]        lrc_acc;
  logic              colon_seen;
  logic              addr_hit;
  logic [7:0]        func_code;
  logic [7:0]        reg_code;
  logic              minus_seen;
  logic [11:0]       data_val;
  logic [7:0]        lrc_rx;
  logic              cr_seen;
  logic [15:0]       own_addr;
  afsp_pkg::result_t expected_results[$];

  // Letters G to O land above 15, so a high digit can overflow its field
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    if (c > afsp_pkg::CHAR_NINE) return 5'(c[3:0]) + 5'd9;
    return 5'(c[3:0]);
  endfunction

  task automatic decode_rx_byte(input logic [7:0] b, input logic restart);
    logic [4:0]        d;
    afsp_pkg::pos_t    p;
    afsp_pkg::result_t r;
    logic [7:0]        lrc_want;
    logic [10:0]       mag;
    logic [22:0]       prod;
    logic [10:0]       scaled;
    d = digit_of(b);
    if (restart || byte_pos >= afsp_pkg::pos_t'(afsp_pkg::FRAME_LENGTH)) begin
      byte_pos = afsp_pkg::POS_START;
    end
    p = byte_pos;
    if (p == afsp_pkg::POS_START) lrc_acc = b;
    else if (p <= afsp_pkg::POS_DATA_LO) lrc_acc = lrc_acc + b;
    case (p)
      afsp_pkg::POS_START:    colon_seen = (b == afsp_pkg::CHAR_COLON);
      afsp_pkg::POS_ADDR_HI:  addr_hit = (b == own_addr[15:8]);
      afsp_pkg::POS_ADDR_LO:  addr_hit = addr_hit && (b == own_addr[7:0]);
      afsp_pkg::POS_FUNC_HI:  func_code = d[4] ? 8'hFF : {d[3:0], 4'h0};
      afsp_pkg::POS_FUNC_LO:  func_code = func_code | 8'(d);
      afsp_pkg::POS_REG_HI:   reg_code = d[4] ? 8'hFF : {d[3:0], 4'h0};
      afsp_pkg::POS_REG_LO:   reg_code = reg_code | 8'(d);
      afsp_pkg::POS_SIGN:     minus_seen = (b == afsp_pkg::CHAR_MINUS);
      afsp_pkg::POS_DATA_HI:  data_val = d[4] ? 12'hFFF : {d[3:0], 8'h00};
      afsp_pkg::POS_DATA_MID: data_val = data_val | {3'b000, d, 4'h0};
      afsp_pkg::POS_DATA_LO:  data_val = data_val | 12'(d);
      afsp_pkg::POS_LRC_HI:   lrc_rx = {d[3:0], 4'h0};
      afsp_pkg::POS_LRC_LO:   lrc_rx = lrc_rx | 8'(d);
      afsp_pkg::POS_CR:       cr_seen = (b == afsp_pkg::CHAR_CR);
      default: ;
    endcase
    if (p != afsp_pkg::POS_LF) begin
      byte_pos = afsp_pkg::pos_t'(p + 1);
    end else begin
      byte_pos = afsp_pkg::POS_START;
      lrc_want = 8'h00 - lrc_acc;
      r.speed_hundredths = '0;
      if (!(colon_seen && cr_seen && b == afsp_pkg::CHAR_LF)) begin
        r.frame_status = afsp_pkg::ST_DELIM;
      end else if (!addr_hit) begin
        r.frame_status = afsp_pkg::ST_ADDR;
      end else if (lrc_want != lrc_rx) begin
        r.frame_status = afsp_pkg::ST_LRC;
      end else if (func_code != afsp_pkg::FUNC_WRITE_REG ||
                   reg_code != afsp_pkg::REG_SPEED) begin
        r.frame_status = afsp_pkg::ST_CODE;
      end else begin
        r.frame_status = afsp_pkg::ST_OK;
        mag = (data_val > 12'(afsp_pkg::DATA_CLAMP)) ? afsp_pkg::DATA_CLAMP
              : data_val[10:0];
        prod = 23'(mag) * 23'(afsp_pkg::SPEED_MUL);
        scaled = 11'(prod >> afsp_pkg::SPEED_SHIFT);
        r.speed_hundredths = minus_seen ? -scaled : scaled;
      end
      expected_results.push_back(r);
    end
  endtask

  task automatic check_result(input logic signed [10:0] speed, input logic [2:0] status);
    afsp_pkg::result_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result word: speed_hundredths %0d frame_status %0d", speed, status);
      mismatch_count++;
    end else begin
      want = expected_results.pop_front();
      if (speed !== want.speed_hundredths) begin
        $error("speed_hundredths: expected %0d, actual %0d", want.speed_hundredths, speed);
        mismatch_count++;
      end
      if (status !== want.frame_status) begin
        $error("frame_status: expected %0d, actual %0d", want.frame_status, status);
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      byte_pos   = afsp_pkg::POS_START;
      lrc_acc    = '0;
      colon_seen = 1'b0;
      addr_hit   = 1'b0;
      func_code  = '0;
      reg_code   = '0;
      minus_seen = 1'b0;
      data_val   = '0;
      lrc_rx     = '0;
      cr_seen    = 1'b0;
      own_addr   = afsp_pkg::OWN_ADDR_RESET;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr == {afsp_pkg::REG_OWN_ADDR, 2'b00}) begin
        own_addr = pwdata[15:0];
      end
      if (res_valid && res_ready) check_result(res_speed, res_status);
      if (rx_valid && rx_ready) decode_rx_byte(rx_byte, rx_restart);
    end
    results_pending = expected_results.size();
  end

endmodule

FILE: tb/sv/ascii_frame_speed_parser_core_test.sv
`timescale 1ns / 100ps
// Top of the parser testbench: clock, reset, frame stimulus, register writes and verdict.
module ascii_frame_speed_parser_core_test;

  localparam int CLK_HALF     = 5;
  localparam int DRAIN_CYCLES = 8;       // result is registered behind its LF; keep margin
  localparam int CYCLE_LIMIT  = 200000;  // bound for the watchdog on a correct run
  localparam int PHASE_WORDS  = 385;

  localparam logic [7:0] CHAR_PLUS = 8'h2B;

  // Ways a generated frame can be damaged on purpose
  typedef enum int {
    FLAW_NONE,
    FLAW_ADDR,
    FLAW_LRC,
    FLAW_DELIM
  } frame_flaw_t;

  logic                        clk;
  logic                        rst_n;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [afsp_pkg::ADDR_W-1:0] paddr;
  logic [afsp_pkg::DATA_W-1:0] pwdata;
  logic [afsp_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  int   send_idle_pct;
  int   recv_stall_pct;
  int   cycle_count;
  int   word_count;
  int   mismatch_count;
  int   results_pending;
  logic need_restart;

  afsp_in_if  in_ch ();
  afsp_out_if out_ch ();

  ascii_frame_speed_parser_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  afsp_frame_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rx_valid        (in_ch.valid),
    .rx_ready        (in_ch.ready),
    .rx_byte         (in_ch.rx_byte),
    .rx_restart      (in_ch.frame_restart),
    .res_valid       (out_ch.valid),
    .res_ready       (out_ch.ready),
    .res_speed       (out_ch.speed_hundredths),
    .res_status      (out_ch.frame_status),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // Result side: stall at random, redraw ready on every falling edge
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: end the run as failed once the cycle limit is reached
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ascii_frame_speed_parser_core verification failed");
      $finish;
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n, input logic lower);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  // Offer one word; called and returns at a falling edge. Valid stays high on
  // return so back-to-back words never drop it within a time step.
  task automatic push_word(input logic [7:0] b, input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.rx_byte       <= b;
    in_ch.frame_restart <= restart;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    word_count++;
    @(negedge clk);
  endtask

  task automatic send_noise(input int n);
    repeat (n) push_word(8'($urandom), 1'($urandom));
    need_restart = 1'b1;
  endtask

  // Build a frame from its fields, damage it as asked, and send the first
  // keep bytes. A wild character in the LRC digits goes in after the LRC is
  // encoded; anywhere else it goes in first so the LRC still matches.
  task automatic send_frame(input logic [15:0] addr, input logic [7:0] func,
                            input logic [7:0] regc, input logic [7:0] sign,
                            input logic [11:0] data, input frame_flaw_t flaw,
                            input int wild_pos, input logic [7:0] wild_char,
                            input logic restart, input int keep);
    logic [7:0] fr [15];
    logic [7:0] sum;
    logic [7:0] lrc;
    logic       lower;
    int         k;
    lower  = 1'($urandom);
    fr[0]  = afsp_pkg::CHAR_COLON;
    fr[1]  = addr[15:8];
    fr[2]  = addr[7:0];
    fr[3]  = hex_char(func[7:4], lower);
    fr[4]  = hex_char(func[3:0], lower);
    fr[5]  = hex_char(regc[7:4], lower);
    fr[6]  = hex_char(regc[3:0], lower);
    fr[7]  = sign;
    fr[8]  = hex_char(data[11:8], lower);
    fr[9]  = hex_char(data[7:4], lower);
    fr[10] = hex_char(data[3:0], lower);
    if (flaw == FLAW_ADDR) begin
      k = 1 + $urandom_range(1);
      fr[k] = fr[k] ^ 8'($urandom_range(1, 255));
    end
    if (wild_pos != 0 && wild_pos <= int'(afsp_pkg::POS_DATA_LO)) fr[wild_pos] = wild_char;
    sum = '0;
    for (k = 0; k <= int'(afsp_pkg::POS_DATA_LO); k++) sum = sum + fr[k];
    lrc = 8'h00 - sum;
    if (flaw == FLAW_LRC) lrc = lrc ^ 8'($urandom_range(1, 255));
    fr[11] = hex_char(lrc[7:4], lower);
    fr[12] = hex_char(lrc[3:0], lower);
    fr[13] = afsp_pkg::CHAR_CR;
    fr[14] = afsp_pkg::CHAR_LF;
    if (wild_pos > int'(afsp_pkg::POS_DATA_LO)) fr[wild_pos] = wild_char;
    if (flaw == FLAW_DELIM) begin
      case ($urandom_range(2))
        0:       k = int'(afsp_pkg::POS_START);
        1:       k = int'(afsp_pkg::POS_CR);
        default: k = int'(afsp_pkg::POS_LF);
      endcase
      fr[k] = fr[k] ^ 8'($urandom_range(1, 255));
    end
    for (k = 0; k < keep; k++) push_word(fr[k], (k == 0) ? restart : 1'b0);
    if (keep == afsp_pkg::FRAME_LENGTH) need_restart = 1'b0;
  endtask

  // One unit of random traffic: mostly good frames, some damaged, some cut short
  task automatic send_random_unit(input logic [15:0] addr);
    int          pick;
    frame_flaw_t flaw;
    logic [7:0]  func;
    logic [7:0]  regc;
    logic [7:0]  sign;
    logic [11:0] data;
    int          wild_pos;
    logic [7:0]  wild_char;
    logic        restart;
    pick = $urandom_range(99);
    if (pick < 7)       flaw = FLAW_DELIM;
    else if (pick < 14) flaw = FLAW_ADDR;
    else if (pick < 21) flaw = FLAW_LRC;
    else                flaw = FLAW_NONE;
    func = afsp_pkg::FUNC_WRITE_REG;
    regc = afsp_pkg::REG_SPEED;
    if ($urandom_range(9) == 0) begin
      if ($urandom_range(1) == 0) func = 8'($urandom);
      else regc = 8'($urandom);
    end
    case ($urandom_range(3))
      0:       sign = afsp_pkg::CHAR_MINUS;
      1:       sign = CHAR_PLUS;
      2:       sign = $urandom_range(1) ? afsp_pkg::CHAR_MINUS : 8'($urandom);
      default: sign = CHAR_PLUS;
    endcase
    case ($urandom_range(3))
      0:       data = 12'($urandom);
      1:       data = 12'($urandom_range(0, 'h500));
      2:       data = 12'($urandom_range('h4F0, 'h510));
      default: data = 12'($urandom_range('h500, 'hFFF));
    endcase
    // Oversized or non-hex digit in a hex field
    wild_pos  = 0;
    wild_char = '0;
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(8))
        0:       wild_pos = int'(afsp_pkg::POS_FUNC_HI);
        1:       wild_pos = int'(afsp_pkg::POS_FUNC_LO);
        2:       wild_pos = int'(afsp_pkg::POS_REG_HI);
        3:       wild_pos = int'(afsp_pkg::POS_REG_LO);
        4:       wild_pos = int'(afsp_pkg::POS_DATA_HI);
        5:       wild_pos = int'(afsp_pkg::POS_DATA_MID);
        6:       wild_pos = int'(afsp_pkg::POS_DATA_LO);
        7:       wild_pos = int'(afsp_pkg::POS_LRC_HI);
        default: wild_pos = int'(afsp_pkg::POS_LRC_LO);
      endcase
      if ($urandom_range(2) != 0) begin
        wild_char = 8'($urandom_range(8'h47, 8'h4F)) | {2'b00, 1'($urandom), 5'b0};
      end else begin
        wild_char = 8'($urandom);
      end
    end
    restart = need_restart | 1'($urandom);
    if (pick >= 93) begin
      send_frame(addr, func, regc, sign, data, flaw, wild_pos, wild_char, 1'b1,
                 $urandom_range(1, afsp_pkg::FRAME_LENGTH - 1));
      send_noise($urandom_range(1, 6));
    end else begin
      send_frame(addr, func, regc, sign, data, flaw, wild_pos, wild_char, restart,
                 afsp_pkg::FRAME_LENGTH);
    end
  endtask

  // Register write with a setup and an access phase; pready is tied high but honor it anyway
  task automatic write_own_addr(input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {afsp_pkg::REG_OWN_ADDR, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drop valid, wait out every expected result, then let the pipeline empty
  task automatic settle_idle();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (results_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [15:0] phase_addr;
    int          phase_end;
    in_ch.valid         = 1'b0;
    in_ch.rx_byte       = '0;
    in_ch.frame_restart = 1'b0;
    out_ch.ready        = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    need_restart        = 1'b1;
    rst_n               = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: a stray word, full-scale reverse under the reset
    // address, then an oversized top data digit that saturates and clamps.
    push_word(8'hFF, 1'b1);
    send_frame(afsp_pkg::OWN_ADDR_RESET, afsp_pkg::FUNC_WRITE_REG, afsp_pkg::REG_SPEED,
               afsp_pkg::CHAR_MINUS, 12'hFFF, FLAW_NONE, 0, 8'h00, 1'b1,
               afsp_pkg::FRAME_LENGTH);
    send_frame(afsp_pkg::OWN_ADDR_RESET, afsp_pkg::FUNC_WRITE_REG, afsp_pkg::REG_SPEED,
               CHAR_PLUS, 12'h000, FLAW_NONE, int'(afsp_pkg::POS_DATA_HI), 8'h4F, 1'b0,
               afsp_pkg::FRAME_LENGTH);

    // Random phases: each sets idling, stalling and the station address
    for (int ph = 0; ph < 4; ph++) begin
      settle_idle();
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          phase_addr     = 16'h0000;
        end
        1: begin
          send_idle_pct  = 53;
          recv_stall_pct = 0;
          phase_addr     = 16'hFFFF;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 53;
          phase_addr     = 16'($urandom);
        end
        default: begin
          send_idle_pct  = 18;
          recv_stall_pct = 18;
          phase_addr     = afsp_pkg::OWN_ADDR_RESET;
        end
      endcase
      write_own_addr(phase_addr);
      @(negedge clk);
      need_restart = 1'b1;
      phase_end = word_count + PHASE_WORDS;
      while (word_count < phase_end) send_random_unit(phase_addr);
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    settle_idle();
    if (mismatch_count == 0) begin
      $display("ascii_frame_speed_parser_core verification clean");
    end else begin
      $display("ascii_frame_speed_parser_core verification failed");
    end
    $finish;
  end

endmodule

FILE: ascii_frame_speed_parser_core.f
hw/rtl/afsp_pkg.sv
hw/rtl/afsp_if.sv
hw/rtl/afsp_cfg.sv
hw/rtl/afsp_frame.sv
hw/rtl/ascii_frame_speed_parser_core.sv
tb/sv/afsp_frame_checker.sv
tb/sv/ascii_frame_speed_parser_core_test.sv
